[sv/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg - shared types and constants for the sample frame packer
// Holds the channel payload types, the front-to-back command, the byte
// phase enum of the serialiser and the reflected CRC-32 byte update.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Fixed field widths
  localparam int unsigned CNT_W = 14;  // rows * cols with 7-bit registers

  // Default dimension limits
  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 64;

  // Command queue depth
  localparam int unsigned QUEUE_DEPTH = 4;

  // Wire constants
  localparam logic [7:0]  HDR0_BYTE = 8'hFF;
  localparam logic [7:0]  HDR1_BYTE = 8'h66;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [15:0] HDR_BYTES = 16'd8;  // header, counter and CRC bytes

  // Configuration register indexes
  localparam logic [1:0] CFG_ROW_COUNT      = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT   = 2'd1;
  localparam logic [1:0] CFG_CAPACITY_LIMIT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [6:0]  ROW_COUNT_RST      = 7'd1;
  localparam logic [6:0]  COLUMN_COUNT_RST   = 7'd1;
  localparam logic [15:0] CAPACITY_LIMIT_RST = 16'hFFFF;

  typedef struct packed {
    logic [15:0] sample;
    logic [15:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        status;
    logic [15:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  row_count;
    logic [6:0]  column_count;
    logic [15:0] capacity_limit;
  } cfg_t;

  // One accepted sample, classified by the front end
  typedef struct packed {
    logic        hdr;     // first sample of a good frame: header and counter
    logic        err;     // first sample of a rejected frame
    logic        send;    // sample bytes go out
    logic        tail;    // closing CRC follows
    logic [15:0] sample;
    logic [15:0] frame_number;
    logic [15:0] frame_length;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_HDR0,
    PH_HDR1,
    PH_FNH,
    PH_FNL,
    PH_SH,
    PH_SL,
    PH_C0,
    PH_C1,
    PH_C2,
    PH_C3,
    PH_ERR
  } phase_e;

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[sv/sample_frame_packer_crc32_core.sv]
// ----------------------------------------------------------------------------
// sample_frame_packer_crc32_core - framed byte stream with CRC-32 trailer
// Packs rows x cols 16-bit samples per frame into a byte stream: header
// FF 66, frame counter, samples high byte first, reflected CRC-32/ISO-HDLC
// least significant byte first. Oversized or zero-sized frames give one error result.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ----------------------------
//  in       sink       in_valid_i / in_stall_o    in_item_t (sample, counter)
//  out      source     out_valid_o / out_stall_i  out_item_t (byte, last, ...)
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  Output: the serialiser puts out one byte per cycle while out_stall_i does
//  not hold it, from a single output register; a sample gives 2 bytes, the
//  first sample of a good frame 6, the last 6, a frame of one sample 10, an
//  error 1. A transaction on the input lands in the command queue the same
//  edge; its first byte then leaves through the output register.
//  Reset: asynchronous, active low; clears the frame position, the queue and
//  the output valid, and loads rows 1, columns 1, capacity 65535.
//  Stalls: out_stall_i holds the output byte; the queue (4 commands) absorbs
//  input meanwhile and in_stall_o rises only when it is full.
//
module sample_frame_packer_crc32_core import sfp_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // byte output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  // Register file: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:      cfg_d.row_count      = cfg_data_i[6:0];
        CFG_COLUMN_COUNT:   cfg_d.column_count   = cfg_data_i[6:0];
        CFG_CAPACITY_LIMIT: cfg_d.capacity_limit = cfg_data_i;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count      <= ROW_COUNT_RST;
      cfg_q.column_count   <= COLUMN_COUNT_RST;
      cfg_q.capacity_limit <= CAPACITY_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: frame position, size check, a command per kept sample or rejected frame
  sfp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // Decouple classification from byte output
  sfp_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Back end: byte sequencing and CRC
  sfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/sfp_front.sv]
// ----------------------------------------------------------------------------
// sfp_front - sample classifier
// Tracks the position within a frame, checks the frame size on its first
// sample and makes a command of each kept sample and of each rejected frame.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; #(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_data_o
);

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] fsamp_q, fsamp_d;
  logic             disc_q, disc_d;

  logic             accept;
  logic             first;
  logic [CNT_W-1:0] cnt;
  logic [16:0]      flen_chk;
  logic             bad;
  logic [CNT_W-1:0] fsamp_eff;
  logic             disc_eff;
  logic             tail;
  logic [CNT_W:0]   idx_inc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign first      = (idx_q == '0);

  always_comb begin
    cnt      = {7'b0, cfg_i.row_count} * {7'b0, cfg_i.column_count};
    flen_chk = 17'(HDR_BYTES) + {2'b00, cnt, 1'b0};
    bad      = (cfg_i.row_count == '0) || (cfg_i.column_count == '0) ||
               ({2'b00, cfg_i.row_count} > 9'(MAX_ROWS)) ||
               ({2'b00, cfg_i.column_count} > 9'(MAX_COLS)) ||
               (flen_chk > {1'b0, cfg_i.capacity_limit}) ||
               (flen_chk > 17'hFFFF);
    fsamp_eff = first ? ((cnt == '0) ? CNT_W'(1) : cnt) : fsamp_q;
    disc_eff  = first ? bad : disc_q;
    idx_inc   = {1'b0, idx_q} + (CNT_W+1)'(1);
    tail      = (idx_inc >= {1'b0, fsamp_eff});

    idx_d   = idx_q;
    fsamp_d = fsamp_q;
    disc_d  = disc_q;
    if (accept) begin
      idx_d   = tail ? '0 : idx_inc[CNT_W-1:0];
      fsamp_d = fsamp_eff;
      disc_d  = tail ? 1'b0 : disc_eff;
    end

    q_data_o.hdr          = first && !bad;
    q_data_o.err          = first && bad;
    q_data_o.send         = !disc_eff;
    q_data_o.tail         = tail && !disc_eff;
    q_data_o.sample       = in_data_i.sample;
    q_data_o.frame_number = in_data_i.frame_number;
    q_data_o.frame_length = HDR_BYTES + {1'b0, fsamp_eff, 1'b0};
    // discarded samples leave nothing behind
    q_push_o = accept && (q_data_o.err || q_data_o.send);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      fsamp_q <= '0;
      disc_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      fsamp_q <= fsamp_d;
      disc_q  <= disc_d;
    end
  end

  // A frame position never runs past the latched frame size
  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> (idx_q < fsamp_q))
    else $error("frame position beyond frame size");

  // Discarding only ever starts with a rejected first sample
  a_disc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(disc_q) |-> $past(accept && first && bad))
    else $error("discarding without a rejected frame");

  // A rejected frame pushes exactly one command, on its first sample
  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (disc_q && !first) |-> !q_push_o)
    else $error("command pushed while discarding");

endmodule

[sv/sfp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// sfp_cmd_fifo - command queue
// Short queue of classified samples between the front end and the
// serialiser, so that either side may stall on its own.
// ----------------------------------------------------------------------------
module sfp_cmd_fifo import sfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_QW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty command queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CNT_QW'(1)))
    else $error("queue fill count did not advance");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_QW'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

[sv/sfp_back.sv]
// ----------------------------------------------------------------------------
// sfp_back - byte serialiser
// Walks each command through its wire bytes, one byte a cycle unless the
// output stalls, keeps the running CRC and drives the output register.
// ----------------------------------------------------------------------------
module sfp_back import sfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  cmd_t      q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e      phase_q, phase_d;
  phase_e      cur;
  phase_e      nxt;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_fin;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        fire;

  assign crc_fin = ~crc_q;

  always_comb begin
    // first byte of a fresh command
    if (phase_q == PH_START) begin
      if (q_head_i.hdr) begin
        cur = PH_HDR0;
      end else if (q_head_i.err) begin
        cur = PH_ERR;
      end else begin
        cur = PH_SH;
      end
    end else begin
      cur = phase_q;
    end

    fire = !q_empty_i && (!out_valid_q || !out_stall_i);

    nxt         = PH_START;
    out_d       = out_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d.last         = 1'b0;
    out_d.status       = 1'b0;
    out_d.frame_length = '0;
    out_d.out_byte     = '0;

    case (cur)
      PH_HDR0: begin
        out_d.out_byte = HDR0_BYTE;
        nxt = PH_HDR1;
      end
      PH_HDR1: begin
        out_d.out_byte = HDR1_BYTE;
        nxt = PH_FNH;
      end
      PH_FNH: begin
        out_d.out_byte = q_head_i.frame_number[15:8];
        crc_d = crc_byte(CRC_INIT, out_d.out_byte);
        nxt = PH_FNL;
      end
      PH_FNL: begin
        out_d.out_byte = q_head_i.frame_number[7:0];
        crc_d = crc_byte(crc_q, out_d.out_byte);
        nxt = PH_SH;
      end
      PH_SH: begin
        out_d.out_byte = q_head_i.sample[15:8];
        crc_d = crc_byte(crc_q, out_d.out_byte);
        nxt = PH_SL;
      end
      PH_SL: begin
        out_d.out_byte = q_head_i.sample[7:0];
        crc_d = crc_byte(crc_q, out_d.out_byte);
        nxt = q_head_i.tail ? PH_C0 : PH_START;
      end
      PH_C0: begin
        out_d.out_byte = crc_fin[7:0];
        nxt = PH_C1;
      end
      PH_C1: begin
        out_d.out_byte = crc_fin[15:8];
        nxt = PH_C2;
      end
      PH_C2: begin
        out_d.out_byte = crc_fin[23:16];
        nxt = PH_C3;
      end
      PH_C3: begin
        out_d.out_byte     = crc_fin[31:24];
        out_d.last         = 1'b1;
        out_d.frame_length = q_head_i.frame_length;
        nxt = PH_START;
      end
      PH_ERR: begin
        out_d.last   = 1'b1;
        out_d.status = 1'b1;
        nxt = PH_START;
      end
      default: begin
        nxt = PH_START;
      end
    endcase

    if (fire) begin
      out_valid_d = 1'b1;
      phase_d     = nxt;
    end else begin
      // hold everything while no byte moves
      out_d   = out_q;
      crc_d   = crc_q;
      phase_d = phase_q;
    end
    q_pop_o = fire && (nxt == PH_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
      crc_q       <= CRC_INIT;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Mid-command phases only exist while the command is still queued
  a_phase_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_START) |-> !q_empty_i)
    else $error("byte phase active with empty queue");

  // A frame length is reported only with a good closing byte
  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.frame_length != '0)) |->
      (out_data_o.last && !out_data_o.status))
    else $error("frame length outside a closing byte");

  // The first CRC byte always follows a sample byte, or holds under a stall
  a_crc_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_C0) |->
      (($past(phase_q) == PH_SL) || ($past(phase_q) == PH_C0)))
    else $error("CRC tail not preceded by sample");

endmodule

[sim/sample_frame_packer_crc32_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_frame_packer_crc32_core_test - self-checking bench for the packer
// Drives samples and register writes into the frame packer. A scoreboard
// predicts every wire byte: header, counter, samples, CRC-32 trailer and the
// size error result. It checks each output transaction in order. Random
// sender gaps and receiver stalls run in most phases.
// ----------------------------------------------------------------------------
module sample_frame_packer_crc32_core_test;
  import sfp_pkg::*;

  // Spare register slot: the block must take the write and ignore it
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // Idle cycles that drain waits after the last owed byte
  localparam int SETTLE_CYCLES = 24;
  // Input samples sent over the whole run, directed phases included
  localparam int RANDOM_SAMPLES = 380;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and frame state, plus the queue of
  // wire bytes still owed by the block
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [6:0]  rows;
    logic [6:0]  cols;
    logic [15:0] capacity;
    int unsigned sample_pos;
    int unsigned frame_samples;
    logic [31:0] crc;
    bit          discarding;
    out_item_t   wire_bytes[$];
    int unsigned mismatches;

    function new();
      rows          = ROW_COUNT_RST;
      cols          = COLUMN_COUNT_RST;
      capacity      = CAPACITY_LIMIT_RST;
      sample_pos    = 0;
      frame_samples = 0;
      crc           = CRC_INIT;
      discarding    = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_ROW_COUNT:      rows = data[6:0];
        CFG_COLUMN_COUNT:   cols = data[6:0];
        CFG_CAPACITY_LIMIT: capacity = data;
        default: ;
      endcase
    endfunction

    function void add_byte(logic [7:0] b, logic lst = 1'b0, logic st = 1'b0,
                           logic [15:0] flen = 16'd0);
      out_item_t r;
      r.out_byte     = b;
      r.last         = lst;
      r.status       = st;
      r.frame_length = flen;
      wire_bytes.push_back(r);
    endfunction

    // Reflected CRC, one input bit at a time, LSB first
    function void fold_byte(logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb  = crc[0] ^ b[i];
        crc = (crc >> 1) ^ (fb ? CRC_POLY : 32'h0);
      end
      add_byte(b);
    endfunction

    // Note one accepted sample; returns the number of wire bytes it causes
    function int take_sample(in_item_t it);
      int unsigned cnt;
      int unsigned flen;
      logic [31:0] fcs;
      int          n_start;
      n_start = wire_bytes.size();
      if (sample_pos == 0) begin
        // Latch the frame size and check it against the limits
        cnt           = int'(rows) * int'(cols);
        flen          = 8 + 2 * cnt;
        frame_samples = (cnt == 0) ? 1 : cnt;
        crc           = CRC_INIT;
        discarding    = (rows == 0) || (rows > MAX_ROWS_DEF) ||
                        (cols == 0) || (cols > MAX_COLS_DEF) ||
                        (flen > capacity) || (flen > 65535);
        if (discarding) begin
          add_byte(8'h00, 1'b1, 1'b1, 16'd0);
        end else begin
          add_byte(HDR0_BYTE);
          add_byte(HDR1_BYTE);
          fold_byte(it.frame_number[15:8]);
          fold_byte(it.frame_number[7:0]);
        end
      end
      if (!discarding) begin
        fold_byte(it.sample[15:8]);
        fold_byte(it.sample[7:0]);
      end
      sample_pos++;
      if (sample_pos >= frame_samples) begin
        if (!discarding) begin
          fcs = ~crc;
          add_byte(fcs[7:0]);
          add_byte(fcs[15:8]);
          add_byte(fcs[23:16]);
          add_byte(fcs[31:24], 1'b1, 1'b0, 16'(8 + 2 * frame_samples));
        end
        sample_pos = 0;
        discarding = 1'b0;
        crc        = CRC_INIT;
      end
      return wire_bytes.size() - n_start;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Check one output transaction against the oldest owed byte
    function void match_byte(out_item_t got);
      out_item_t want;
      if (wire_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = wire_bytes.pop_front();
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("last", want.last, got.last);
        compare_field("status", want.status, got.status);
        compare_field("frame_length", want.frame_length, got.frame_length);
      end
    endfunction

    function int bytes_outstanding();
      return wire_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its stimulus signals; every input starts known
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  sample_frame_packer_crc32_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  frame_scoreboard board;

  // Traffic shaping knobs, retuned per phase. Zero disables gaps or stalls.
  int gap_max    = 0;
  int stall_max  = 0;
  int burst_left = 1;
  int stall_run  = 0;
  int accepted   = 0;  // input samples taken by the block so far

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Receiver: alternate runs of flowing and stalled cycles of random length,
  // so that stalls land on every byte phase of the serialiser
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall_i || stall_max == 0) begin
      out_stall_i <= 1'b0;
      stall_run   <= $urandom_range(1, 24);
    end else begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(1, stall_max);
    end
  end

  // Check every byte transaction that completes at this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.match_byte(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one sample, hold it until taken, then perhaps end the burst
  // --------------------------------------------------------------------------
  task automatic push_sample(logic [15:0] s, logic [15:0] fn);
    in_item_t it;
    it.sample       = s;
    it.frame_number = fn;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    void'(board.take_sample(it));
    accepted++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid, wait for every owed byte, then idle for SETTLE_CYCLES
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.bytes_outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers, optionally the spare slot too. Row and column
  // writes carry random junk above bit 6, which the block must drop.
  task automatic configure(logic [6:0] r, logic [6:0] c, logic [15:0] cap,
                           bit spare);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    int          n;
    idx[0] = CFG_ROW_COUNT;      val[0] = {9'($urandom), r};
    idx[1] = CFG_COLUMN_COUNT;   val[1] = {9'($urandom), c};
    idx[2] = CFG_CAPACITY_LIMIT; val[2] = cap;
    idx[3] = CFG_SPARE;          val[3] = 16'($urandom);
    n = spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_reg(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [6:0]  r;
    logic [6:0]  c;
    logic [15:0] cap;
    int          frames;
    int          count;

    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, one-sample frames: field extremes and alternating bits
    push_sample(16'h0000, 16'h0000);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'h8001, 16'h7FFE);
    push_sample(16'h5AA5, 16'hA55A);
    drain();

    // Capacity exactly the frame length, then one short, then zero
    gap_max   = 3;
    stall_max = 4;
    configure(7'd1, 7'd1, 16'd10, 1'b1);
    push_sample(16'h1234, 16'hBEEF);
    drain();
    configure(7'd1, 7'd1, 16'd9, 1'b0);
    push_sample(16'hFFFF, 16'h0001);
    drain();
    configure(7'd1, 7'd1, 16'd0, 1'b0);
    push_sample(16'h0000, 16'hFFFF);
    drain();

    // Zero rows or zero columns: error frame spans a single sample
    configure(7'd0, 7'd5, 16'hFFFF, 1'b0);
    push_sample(16'hC3C3, 16'h3C3C);
    drain();
    configure(7'd5, 7'd0, 16'hFFFF, 1'b0);
    push_sample(16'h3C3C, 16'hC3C3);
    drain();

    // Dimensions above the maximum: one error, rest of the frame dropped
    configure(7'd127, 7'd1, 16'hFFFF, 1'b0);
    repeat (127) push_sample(pick_sample(), 16'($urandom));
    drain();
    configure(7'd1, 7'd65, 16'hFFFF, 1'b0);
    repeat (65) push_sample(pick_sample(), 16'($urandom));
    drain();

    // Registers rewritten mid-frame: the open frame keeps its latched size
    configure(7'd2, 7'd2, 16'hFFFF, 1'b0);
    push_sample(16'hA001, 16'h4242);
    push_sample(16'hA002, 16'h0000);
    drain();
    configure(7'd1, 7'd3, 16'hFFFF, 1'b0);
    repeat (5) push_sample(pick_sample(), 16'($urandom));
    drain();

    // Multi-row frame whose length lands exactly on the capacity
    configure(7'd3, 7'd2, 16'd20, 1'b0);
    repeat (6) push_sample(pick_sample(), 16'($urandom));
    drain();

    // Random phases, mostly well-formed frames of small size, until the
    // sample budget is spent
    while (accepted < RANDOM_SAMPLES) begin
      frames = $urandom_range(2, 6);
      cap    = 16'hFFFF;
      r      = 7'($urandom_range(1, 6));
      c      = 7'($urandom_range(1, 6));
      case ($urandom_range(0, 9))
        0: begin
          r      = 7'd64;
          c      = 7'd1;
          frames = 1;
        end
        1: begin
          r      = 7'd1;
          c      = 7'd64;
          frames = 1;
        end
        2: begin
          r = 7'd0;
          c = 7'($urandom_range(0, 127));
        end
        3: begin
          r      = 7'($urandom_range(65, 127));
          c      = 7'($urandom_range(0, 1));
          frames = 1;
          if ($urandom_range(0, 1) == 1) {r, c} = {c, r};
        end
        4: cap = 16'(8 + 2 * int'(r) * int'(c));
        5: cap = 16'($urandom_range(0, 7 + 2 * int'(r) * int'(c)));
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            cap = 16'($urandom_range(8 + 2 * int'(r) * int'(c), 65535));
          end
        end
      endcase
      count = int'(r) * int'(c);
      if (count == 0) count = 1;
      count = frames * count;
      // Now and then stop part way through a frame
      if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_SAMPLES - accepted) count = RANDOM_SAMPLES - accepted;
      gap_max   = $urandom_range(0, 2) * 6;
      stall_max = $urandom_range(0, 2) * 5;
      configure(r, c, cap, $urandom_range(0, 7) == 0);
      repeat (count) push_sample(pick_sample(), 16'($urandom));
      drain();
    end

    if (board.mismatches == 0 && board.bytes_outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
